// ===== rtl/ssc_pkg.sv =====
// ssc_pkg: shared constants, codes and payload types for the subset sequence counter.
// No dependencies; compiled first.
`default_nettype none

package ssc_pkg;

	// default vector width
	localparam int SSC_WIDTH = 32;

	// field widths fixed by the channel formats
	localparam int LOAD_W     = 32;
	localparam int VEC_OUT_W  = 32;
	localparam int CNT_OUT_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	// item function codes
	localparam logic FUNC_ADVANCE = 1'b0;
	localparam logic FUNC_LOAD    = 1'b1;

	// step modes
	localparam logic MODE_BINARY = 1'b0;
	localparam logic MODE_CHORD  = 1'b1;

	// output form bits
	localparam int FORM_GRAY_BIT = 0;
	localparam int FORM_REV_BIT  = 1;

	typedef logic [1:0] ssc_form_t;

	localparam ssc_form_t FORM_PLAIN = 2'b00;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_MODE,
		REG_OUTPUT_FORM
	} ssc_cfg_reg_t;

	typedef struct packed {
		logic      step_mode;
		ssc_form_t output_form;
	} ssc_cfg_t;

	typedef struct packed {
		logic              func;
		logic [LOAD_W-1:0] load_value;
	} ssc_in_t;

	typedef struct packed {
		logic [VEC_OUT_W-1:0] vector_out;
		logic [CNT_OUT_W-1:0] ones_count;
		logic                 rolled_over;
	} ssc_out_t;

endpackage

`default_nettype wire

// ===== rtl/subset_sequence_counter.sv =====
// subset_sequence_counter: top level; input, vector and result registers around
// ssc_step and ssc_format. Depends on ssc_pkg, ssc_step, ssc_format.
`default_nettype none

// Holds one WIDTH-bit vector. Each input transfer either loads it (func = load,
// load_value zero-extended or truncated to WIDTH) or advances it one step: in
// binary mode it counts up modulo 2^WIDTH, in chord mode it steps to the next
// vector with the same number of set bits, and once that set is exhausted it
// moves to the lowest popcount+1 bits set (all ones wraps to zero). Every item
// yields exactly one result transfer with the new vector (plain, Gray, reversed
// or Gray then reversed, low 32 bits shown), its popcount and a rollover flag.
// Throughput is one item per clock unless out_ready stalls the pipeline: the
// item sits in an input register, the combinational step logic writes the
// vector register, and the format/popcount logic writes the result register,
// so the three stages overlap freely. in_ready follows out_ready through the
// stage occupancy bits. The config port (step_mode, output_form) should only
// be written while no item is in flight; writes to unused indexes are
// dropped.

module subset_sequence_counter import ssc_pkg::*; #(
	parameter int WIDTH = SSC_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ssc_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ssc_out_t              out_data,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// config registers
	ssc_cfg_t cfg_q;

	// stage 1: accepted item
	logic     valid_s1;
	ssc_in_t  item_s1;

	// stage 2: the vector register doubles as the stage payload
	logic             valid_s2;
	logic [WIDTH-1:0] bit_vector_q;
	logic             rolled_s2;

	// stage 3: result register
	logic     valid_s3;
	ssc_out_t result_s3;

	logic adv_s2;
	logic adv_s3;
	logic move_s1;
	logic move_s2;

	logic [WIDTH-1:0]     step_vec;
	logic                 step_rolled;
	logic [VEC_OUT_W-1:0] fmt_vec;
	logic [CNT_OUT_W-1:0] fmt_cnt;

	// a stage can take a new transfer when empty or when it empties this cycle
	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign in_ready = !valid_s1 || adv_s2;
	assign move_s1  = valid_s1 && adv_s2;
	assign move_s2  = valid_s2 && adv_s3;

	assign out_valid = valid_s3;
	assign out_data  = result_s3;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_mode   <= MODE_CHORD;
			cfg_q.output_form <= FORM_PLAIN;
		end else if (cfg_wen) begin
			case (ssc_cfg_reg_t'(cfg_index))
				REG_STEP_MODE: begin
					cfg_q.step_mode <= cfg_data[0];
				end
				REG_OUTPUT_FORM: begin
					cfg_q.output_form <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ssc_step #(
		.WIDTH(WIDTH)
	) u_step (
		.vec       (bit_vector_q),
		.func      (item_s1.func),
		.step_mode (cfg_q.step_mode),
		.load_value(item_s1.load_value),
		.next_vec  (step_vec),
		.rolled    (step_rolled)
	);

	ssc_format #(
		.WIDTH(WIDTH)
	) u_format (
		.vec        (bit_vector_q),
		.output_form(cfg_q.output_form),
		.vector_out (fmt_vec),
		.ones_count (fmt_cnt)
	);

	// occupancy and vector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			bit_vector_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			// vector only moves when an item steps into stage 2
			if (move_s1) begin
				bit_vector_q <= step_vec;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (move_s1) begin
			rolled_s2 <= step_rolled;
		end
		if (move_s2) begin
			result_s3.vector_out  <= fmt_vec;
			result_s3.ones_count  <= fmt_cnt;
			result_s3.rolled_over <= rolled_s2;
		end
	end

	// stalled input means every stage is full
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3))
		else $error("in_ready low with an empty stage");

	// a load lands in the vector register
	a_load_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && item_s1.func == FUNC_LOAD)
		|=> bit_vector_q == WIDTH'($past(item_s1.load_value)))
		else $error("loaded value not stored");

	// a chord step without rollover keeps the popcount
	a_chord_count: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && item_s1.func == FUNC_ADVANCE && cfg_q.step_mode == MODE_CHORD
			&& !step_rolled)
		|=> $countones(bit_vector_q) == $past($countones(bit_vector_q)))
		else $error("chord step changed popcount");

	// a chord rollover leaves a run of ones starting at bit 0
	a_chord_roll: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && item_s1.func == FUNC_ADVANCE && cfg_q.step_mode == MODE_CHORD
			&& step_rolled)
		|=> (bit_vector_q & (bit_vector_q + WIDTH'(1))) == '0)
		else $error("chord rollover not a low run of ones");

endmodule

`default_nettype wire

// ===== rtl/ssc_step.sv =====
// ssc_step: next-vector logic (load, binary increment, same-popcount chord step).
// Depends on ssc_pkg.
`default_nettype none

module ssc_step import ssc_pkg::*; #(
	parameter int WIDTH = SSC_WIDTH
) (
	input  logic [WIDTH-1:0]  vec,
	input  logic              func,
	input  logic              step_mode,
	input  logic [LOAD_W-1:0] load_value,
	output logic [WIDTH-1:0]  next_vec,
	output logic              rolled
);

	localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] low_bit;
	logic [IDX_W-1:0] low_idx;
	logic [WIDTH:0]   run_sum;
	logic [WIDTH:0]   run_flip;
	logic [WIDTH-1:0] packed_run;
	logic             can_move;
	logic [WIDTH-1:0] chord_vec;
	logic [WIDTH-1:0] bin_vec;

	// lowest set bit, one-hot, and its position
	assign low_bit = vec & (~vec + WIDTH'(1));

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < WIDTH; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | IDX_W'(i);
			end
		end
	end

	// adding the lowest bit ripples through the lowest run of ones;
	// a carry out of the top means the run reaches the top bit
	assign run_sum    = {1'b0, vec} + {1'b0, low_bit};
	assign run_flip   = run_sum ^ {1'b0, vec};
	assign packed_run = WIDTH'((run_flip >> 2) >> low_idx);
	assign can_move   = (|vec) && !run_sum[WIDTH];

	// no move left: the top run (or nothing) becomes one more low ones; all ones wraps
	always_comb begin
		if (can_move) begin
			chord_vec = run_sum[WIDTH-1:0] | packed_run;
		end else if (&vec) begin
			chord_vec = '0;
		end else begin
			chord_vec = ((vec >> low_idx) << 1) | WIDTH'(1);
		end
	end

	assign bin_vec = vec + WIDTH'(1);

	always_comb begin
		if (func == FUNC_LOAD) begin
			next_vec = WIDTH'(load_value);
			rolled   = 1'b0;
		end else if (step_mode == MODE_BINARY) begin
			next_vec = bin_vec;
			rolled   = &vec;
		end else begin
			next_vec = chord_vec;
			rolled   = !can_move;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ssc_format.sv =====
// ssc_format: output transform (Gray / bit reverse) and popcount of the stored vector.
// Depends on ssc_pkg.
`default_nettype none

module ssc_format import ssc_pkg::*; #(
	parameter int WIDTH = SSC_WIDTH
) (
	input  logic [WIDTH-1:0]     vec,
	input  ssc_form_t            output_form,
	output logic [VEC_OUT_W-1:0] vector_out,
	output logic [CNT_OUT_W-1:0] ones_count
);

	localparam int NGRP  = (WIDTH + 7) / 8;
	localparam int PAD_W = NGRP * 8;
	localparam int CW    = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] gray_sel;
	logic [WIDTH-1:0] rev_vec;
	logic [WIDTH-1:0] shown;
	logic [PAD_W-1:0] padded;
	logic [3:0]       grp_cnt [NGRP];
	logic [CW-1:0]    total;

	assign gray_sel = output_form[FORM_GRAY_BIT] ? (vec ^ (vec >> 1)) : vec;

	always_comb begin
		for (int i = 0; i < WIDTH; i++) begin
			rev_vec[WIDTH-1-i] = gray_sel[i];
		end
	end

	assign shown      = output_form[FORM_REV_BIT] ? rev_vec : gray_sel;
	assign vector_out = VEC_OUT_W'(shown);

	// popcount: byte counts, then a sum of the byte counts
	assign padded = PAD_W'(vec);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_cnt[g] = '0;
			for (int b = 0; b < 8; b++) begin
				grp_cnt[g] = grp_cnt[g] + 4'(padded[g*8+b]);
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total + CW'(grp_cnt[g]);
		end
	end

	assign ones_count = CNT_OUT_W'(total);

endmodule

`default_nettype wire
